@@ hw/rtl/msl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Median of two sorted lists: shared package
// Payload types, item kinds, status codes and the controller/datapath link.
// ----------------------------------------------------------------------------
package msl_pkg;

  localparam int unsigned ValueWidth     = 32;
  localparam int unsigned ListDepthDflt  = 1024;

  typedef enum logic [1:0] {
    KIND_LOAD_A  = 2'd0,
    KIND_LOAD_B  = 2'd1,
    KIND_COMPUTE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]                   kind;
    logic signed [ValueWidth-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueWidth:0] median_doubled;
    logic [1:0]                 status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;
    logic out_busy;
  } stat_t;

endpackage

@@ hw/rtl/median_of_two_sorted_lists.sv @@
`timescale 1ns / 1ps
// Loads are accepted one per cycle while no compute walk is in progress.
// A compute transaction starts the merge walk, which takes one element per cycle
// (no steps when both lists are empty); when it ends, the result is registered and
// out_valid_o rises, and the next transaction can be accepted.
// Loads are accepted while a result waits; a new compute waits for it.
// Reset (rst_ni, async, active low) empties both lists and clears overflow.
// ----------------------------------------------------------------------------
// Median of two sorted lists
// Holds two ascending lists and returns twice the median of their merge.
// ----------------------------------------------------------------------------
module median_of_two_sorted_lists #(
  parameter int unsigned LIST_DEPTH = msl_pkg::ListDepthDflt
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  msl_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output msl_pkg::out_item_t out_data_o
);
  import msl_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  msl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_data_i.kind),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  msl_dpath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ hw/rtl/msl_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Median of two sorted lists: controller
// Sequences loads, the merge walk and the hand-off of the result.
// ----------------------------------------------------------------------------
module msl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    in_kind_i,
  output logic          in_ready_o,
  input  msl_pkg::stat_t stat_i,
  output msl_pkg::cmd_t  cmd_o
);
  import msl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // A compute transaction waits until the previous result has been taken.
  assign in_ready_o = (state_q == ST_IDLE) &&
                      !((in_kind_i == KIND_COMPUTE) && stat_i.out_busy);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.load_a = accept && (in_kind_i == KIND_LOAD_A);
    cmd_o.load_b = accept && (in_kind_i == KIND_LOAD_B);
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_kind_i == KIND_COMPUTE)) begin
          cmd_o.start = 1'b1;
          state_d     = ST_WALK;
        end
      end
      ST_WALK: begin
        if (stat_i.walk_done) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/msl_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Median of two sorted lists: datapath
// List memories, fill counts, merge-walk registers and the result register.
// ----------------------------------------------------------------------------
module msl_dpath #(
  parameter int unsigned LIST_DEPTH = msl_pkg::ListDepthDflt
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  msl_pkg::in_item_t  in_data_i,
  input  msl_pkg::cmd_t      cmd_i,
  output msl_pkg::stat_t     stat_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output msl_pkg::out_item_t out_data_o
);
  import msl_pkg::*;

  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned TW = CW + 1;

  logic signed [ValueWidth-1:0] mem_a [LIST_DEPTH];
  logic signed [ValueWidth-1:0] mem_b [LIST_DEPTH];
  logic signed [ValueWidth-1:0] rd_a_q, rd_b_q;

  logic [CW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CW-1:0] ia_q, ia_d, ib_q, ib_d;
  logic [TW-1:0] steps_q, steps_d, total;
  logic          ovf_q, ovf_d;
  logic signed [ValueWidth-1:0] prev_q, prev_d, cur_q, cur_d;

  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;

  logic a_avail, b_avail, take_a;
  logic signed [ValueWidth:0] prev_x, cur_x;

  assign total   = TW'(cnt_a_q) + TW'(cnt_b_q);
  assign a_avail = ia_q < cnt_a_q;
  assign b_avail = ib_q < cnt_b_q;
  // Ties go to list B; list A is used only while it still has elements.
  assign take_a  = a_avail && (!b_avail || (rd_a_q < rd_b_q));
  assign prev_x  = {prev_q[ValueWidth-1], prev_q};
  assign cur_x   = {cur_q[ValueWidth-1], cur_q};

  always_comb begin
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    ia_d        = ia_q;
    ib_d        = ib_q;
    steps_d     = steps_q;
    ovf_d       = ovf_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if (cmd_i.load_a) begin
      if (cnt_a_q < CW'(LIST_DEPTH)) cnt_a_d = cnt_a_q + 1'b1;
      else ovf_d = 1'b1;
    end
    if (cmd_i.load_b) begin
      if (cnt_b_q < CW'(LIST_DEPTH)) cnt_b_d = cnt_b_q + 1'b1;
      else ovf_d = 1'b1;
    end
    if (cmd_i.start) begin
      // The walk visits merged positions zero through total/2.
      steps_d = (total == '0) ? '0 : ((total >> 1) + 1'b1);
    end
    if (cmd_i.step) begin
      prev_d  = cur_q;
      steps_d = steps_q - 1'b1;
      if (take_a) begin
        cur_d = rd_a_q;
        ia_d  = ia_q + 1'b1;
      end else begin
        cur_d = rd_b_q;
        ib_d  = ib_q + 1'b1;
      end
    end
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
      if (total == '0) out_d.median_doubled = '0;
      else if (total[0]) out_d.median_doubled = cur_x + cur_x;
      else out_d.median_doubled = prev_x + cur_x;
      if (ovf_q) out_d.status = STATUS_OVERFLOW;
      else if (total == '0) out_d.status = STATUS_EMPTY;
      else out_d.status = STATUS_OK;
      cnt_a_d = '0;
      cnt_b_d = '0;
      ia_d    = '0;
      ib_d    = '0;
      ovf_d   = 1'b0;
    end
  end

  // Memories: write at the fill count, read at the next walk index so the
  // registered read data always shows the current heads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a && (cnt_a_q < CW'(LIST_DEPTH))) begin
      mem_a[cnt_a_q[AW-1:0]] <= in_data_i.value;
    end
    rd_a_q <= mem_a[ia_d[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_b && (cnt_b_q < CW'(LIST_DEPTH))) begin
      mem_b[cnt_b_q[AW-1:0]] <= in_data_i.value;
    end
    rd_b_q <= mem_b[ib_d[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      ia_q        <= '0;
      ib_q        <= '0;
      steps_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      ia_q        <= ia_d;
      ib_q        <= ib_d;
      steps_q     <= steps_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    cur_q  <= cur_d;
    out_q  <= out_d;
  end

  assign stat_o.walk_done = (steps_q == '0);
  assign stat_o.out_busy  = out_valid_q;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;

endmodule
